/* rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds across reset
`define CHK_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/fqpr_pkg.sv */
package fqpr_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int WORD_WIDTH  = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // fixed field widths of the transaction payloads
  localparam int CMD_W   = 2;
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REV  = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [DATA_W-1:0]  data_in;
    logic [INDEX_W-1:0] peek_index;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

endpackage

/* rtl/fqpr_core.sv */
module fqpr_core import fqpr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  cmd_t cmd,
  output rsp_t rsp
);

  localparam int SUM_W = CNT_W + 1;

  logic [WORD_WIDTH-1:0] store [QUEUE_DEPTH];
  logic [PTR_W-1:0]      front, front_next;
  logic [CNT_W-1:0]      count, count_next;
  logic                  reversed, reversed_next;

  logic [CNT_W-1:0]      rd_pos, run;
  logic [PTR_W-1:0]      rd_slot, wr_slot, front_inc, front_dec;
  logic [WORD_WIDTH-1:0] rd_word, wr_word, data;
  logic [CNT_W-1:0]      idx;
  logic                  wr_en;
  logic [STAT_W-1:0]     status;

  // ring slot of base plus an offset below the depth
  function automatic logic [PTR_W-1:0] wrap_slot(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] offs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offs);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // pointer neighbours
  assign front_inc = (front == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? PTR_W'(QUEUE_DEPTH - 1) : front - 1'b1;

  // read side: logical position to physical slot
  assign idx     = CNT_W'(cmd.peek_index);
  assign rd_pos  = (cmd.command == CMD_PEEK) ? idx : '0;
  assign run     = reversed ? (count - 1'b1 - rd_pos) : rd_pos;
  assign rd_slot = wrap_slot(front, run);
  assign rd_word = store[rd_slot];

  // write side: back of the logical order
  assign wr_slot = reversed ? front_dec : wrap_slot(front, count);
  assign wr_word = cmd.data_in[WORD_WIDTH-1:0];

  // command decode
  always_comb begin
    front_next    = front;
    count_next    = count;
    reversed_next = reversed;
    wr_en         = 1'b0;
    data          = '0;
    status        = ST_OK;
    unique case (cmd.command)
      CMD_ENQ: begin
        if (count == CNT_W'(QUEUE_DEPTH)) begin
          status = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + 1'b1;
          if (reversed) begin
            front_next = front_dec;
          end
        end
      end
      CMD_DEQ: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else begin
          data       = rd_word;
          count_next = count - 1'b1;
          if (!reversed) begin
            front_next = front_inc;
          end
        end
      end
      CMD_PEEK: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else if (idx >= count) begin
          status = ST_RANGE;
        end else begin
          data = rd_word;
        end
      end
      CMD_REV: begin
        reversed_next = !reversed;
      end
      default: begin
      end
    endcase
  end

  assign rsp.data_out    = DATA_W'(data);
  assign rsp.status      = status;
  assign rsp.entry_count = COUNT_W'(count_next);

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      store[wr_slot] <= wr_word;
    end
  end

  // queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      reversed <= 1'b0;
    end else if (fire) begin
      front    <= front_next;
      count    <= count_next;
      reversed <= reversed_next;
    end
  end

endmodule

/* rtl/fifo_queue_with_peek_reverse.sv */
// Bounded queue of 16 words of 32 bits, held in a ring buffer, with enqueue, dequeue,
// peek at a position from the front and reverse. Each command's response is registered
// and shows in the cycle after the command is taken. Each command is a single pointer
// update plus one read or write of the register-based entry store, done in the
// accepting cycle, which sets the rate of one command per clock unless a waiting
// response is stalled. A new command is taken while a response still waits, as long
// as the response register is freed in the same cycle. Reverse only flips the
// direction of the ring, so no entry moves. Errors come back as status codes.
module fifo_queue_with_peek_reverse import fqpr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic fire;
  rsp_t rsp_comb;

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign fire      = cmd_valid && cmd_ready;

  fqpr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .cmd  (cmd),
    .rsp  (rsp_comb)
  );

  // response register
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_comb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

/* rtl/fqpr_checker.sv */
`include "assert_macros.svh"

module fqpr_checker import fqpr_pkg::*; (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input cmd_t cmd,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // no response straight out of reset
  `CHK_ASSERT_RST(a_idle_after_rst, rst |=> !rsp_valid, "response valid after reset")

  // count never exceeds the depth
  `CHK_ASSERT(a_count_bound, rsp_valid |-> rsp.entry_count <= COUNT_W'(QUEUE_DEPTH), "count above depth")

  // returned data only with ok status
  `CHK_ASSERT(a_data_ok, (rsp_valid && rsp.data_out != '0) |-> rsp.status == ST_OK, "data on error")

  // free output register means command side is open
  `CHK_ASSERT(a_ready_free, !rsp_valid |-> cmd_ready, "stalled with empty output")

  // stalled response holds
  `CHK_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)), "response changed")

endmodule

bind fifo_queue_with_peek_reverse fqpr_checker u_fqpr_checker (.*);

/* sim/fqpr_queue_check.sv */
module fqpr_queue_check import fqpr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  logic cmd_ready,
  input  cmd_t cmd,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the ring buffer
  logic [DATA_W-1:0] word_store [QUEUE_DEPTH];
  int head_slot;
  int held_words;
  bit order_flipped;

  // responses still owed by the block, oldest first
  rsp_t owed_rsp [$];

  // physical slot of a position counted from the logical front
  function automatic int slot_at(input int pos);
    int run;
    run = order_flipped ? (held_words - 1 - pos) : pos;
    return (head_slot + run) % QUEUE_DEPTH;
  endfunction

  // apply one command to the shadow queue and work out its response
  task automatic apply_command(input cmd_t c, output rsp_t r);
    r = '0;
    r.status = ST_OK;
    case (c.command)
      CMD_ENQ: begin
        if (held_words >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (order_flipped) begin
            head_slot = (head_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            word_store[head_slot] = c.data_in;
          end else begin
            word_store[(head_slot + held_words) % QUEUE_DEPTH] = c.data_in;
          end
          held_words++;
        end
      end
      CMD_DEQ: begin
        if (held_words == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = word_store[slot_at(0)];
          if (!order_flipped) head_slot = (head_slot + 1) % QUEUE_DEPTH;
          held_words--;
        end
      end
      CMD_PEEK: begin
        if (held_words == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(c.peek_index) >= held_words) begin
          r.status = ST_RANGE;
        end else begin
          r.data_out = word_store[slot_at(int'(c.peek_index))];
        end
      end
      default: begin
        order_flipped = !order_flipped;
      end
    endcase
    r.entry_count = COUNT_W'(held_words);
  endtask

  // predict on each command transaction, compare on each response transaction
  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst) begin
      foreach (word_store[i]) word_store[i] = '0;
      head_slot = 0;
      held_words = 0;
      order_flipped = 1'b0;
      owed_rsp.delete();
      fail_count = 0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        apply_command(cmd, want);
        owed_rsp.push_back(want);
      end
      if (rsp_valid && rsp_ready) begin
        got = rsp;
        if (owed_rsp.size() == 0) begin
          $error("response with nothing owed: data_out %h status %0d entry_count %0d",
                 got.data_out, got.status, got.entry_count);
          fail_count++;
        end else begin
          want = owed_rsp.pop_front();
          if (got.data_out !== want.data_out) begin
            $error("data_out: expected %h, got %h", want.data_out, got.data_out);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            fail_count++;
          end
        end
      end
    end
    outstanding = owed_rsp.size();
  end

endmodule

/* sim/fifo_queue_with_peek_reverse_tb.sv */
module fifo_queue_with_peek_reverse_tb import fqpr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 1625;
  localparam int PHASE_ITEMS  = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int fail_count;
  int owed_count;

  // idling on or off per side, changed between phases
  bit cmd_gaps_on = 1'b1;
  bit rsp_gaps_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fifo_queue_with_peek_reverse dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  fqpr_queue_check queue_check (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .fail_count(fail_count),
    .outstanding(owed_count)
  );

  function automatic cmd_t make_cmd(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] word,
                                    input logic [INDEX_W-1:0] pos);
    cmd_t c;
    c.command = op;
    c.data_in = word;
    c.peek_index = pos;
    return c;
  endfunction

  // offer one command transaction; called and returns at a falling edge
  task automatic send_command(input cmd_t c);
    int gap;
    gap = cmd_gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // response side: random stall before taking each transaction
  initial begin : rsp_side
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = rsp_gaps_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // end the run when neither channel moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int enq_cut;
    int deq_cut;
    int peek_cut;
    int roll;
    logic [CMD_W-1:0] op;
    logic [DATA_W-1:0] word;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty queue corner cases
    send_command(make_cmd(CMD_DEQ, 32'h1234_5678, 4'd0));
    send_command(make_cmd(CMD_PEEK, '0, 4'd15));
    send_command(make_cmd(CMD_REV, '1, 4'd0));
    // single entry: reverse changes nothing, peek past the end
    send_command(make_cmd(CMD_ENQ, 32'h0000_0000, 4'd0));
    send_command(make_cmd(CMD_REV, '0, 4'd0));
    send_command(make_cmd(CMD_PEEK, '0, 4'd0));
    send_command(make_cmd(CMD_PEEK, '0, 4'd1));
    send_command(make_cmd(CMD_ENQ, 32'hFFFF_FFFF, 4'd0));
    // fill to the top, then push once more
    for (int i = 0; i < QUEUE_DEPTH - 2; i++) begin
      send_command(make_cmd(CMD_ENQ, (i % 2) ? 32'hA5A5_5A5A : 32'h5A5A_A5A5, 4'(i)));
    end
    send_command(make_cmd(CMD_ENQ, 32'hDEAD_BEEF, 4'd0));
    send_command(make_cmd(CMD_PEEK, '0, 4'd15));
    send_command(make_cmd(CMD_REV, '0, 4'd0));
    send_command(make_cmd(CMD_DEQ, '0, 4'd0));

    // random phases, each with its own command mix and idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        cmd_gaps_on = ($urandom_range(0, 3) != 0);
        rsp_gaps_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 3))
          0: begin enq_cut = 60; deq_cut = 75; peek_cut = 90; end  // mostly filling
          1: begin enq_cut = 15; deq_cut = 75; peek_cut = 90; end  // mostly draining
          2: begin enq_cut = 30; deq_cut = 60; peek_cut = 85; end  // balanced
          default: begin enq_cut = 25; deq_cut = 45; peek_cut = 90; end  // peek heavy
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < enq_cut) op = CMD_ENQ;
      else if (roll < deq_cut) op = CMD_DEQ;
      else if (roll < peek_cut) op = CMD_PEEK;
      else op = CMD_REV;
      case ($urandom_range(0, 7))
        0: word = '0;
        1: word = '1;
        default: word = $urandom;
      endcase
      send_command(make_cmd(op, word, INDEX_W'($urandom_range(0, 15))));
    end
    cmd_valid <= 1'b0;

    // drain outstanding responses, then a short settle
    while (owed_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
